### rtl/core/isi_pkg.sv
// Shared types and constants for the interval set insert block.
package isi_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int DEFAULT_ID_BITS     = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef enum logic [2:0] {
    STAT_NEW,
    STAT_MERGED,
    STAT_EMPTY,
    STAT_FULL,
    STAT_READ_OK,
    STAT_READ_BEYOND
  } isi_status_t;

  typedef struct packed {
    logic        command;
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic [3:0]  read_index;
  } isi_item_t;

  typedef struct packed {
    isi_status_t status;
    logic [4:0]  entry_index;
    logic [31:0] entry_low;
    logic [31:0] entry_high;
    logic [4:0]  entry_count;
  } isi_result_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_EVAL,
    CELL_PLACE,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     make_room;
  } cell_ctl_t;

endpackage

### rtl/core/isi_cell.sv
// One table cell: holds one interval, compares it against the key and loads the key or a neighbor's interval.
module isi_cell #(
  parameter int ID_BITS = isi_pkg::DEFAULT_ID_BITS
) (
  input  logic               clk,
  input  isi_pkg::cell_ctl_t ctl,
  input  logic               in_use,
  input  logic [ID_BITS-1:0] key_lo,
  input  logic [ID_BITS-1:0] key_hi,
  input  logic               next_le_lo,
  input  logic               prev_a,
  input  logic [ID_BITS-1:0] prev_low,
  input  logic [ID_BITS-1:0] prev_high,
  input  logic [ID_BITS-1:0] next_low,
  input  logic [ID_BITS-1:0] next_high,
  output logic               le_lo,
  output logic               a,
  output logic               b,
  output logic               at_s,
  output logic [ID_BITS-1:0] low,
  output logic [ID_BITS-1:0] high
);
  import isi_pkg::*;

  logic le_hi;
  logic back;
  logic tail;

  assign le_lo = in_use && (low <= key_lo);
  assign le_hi = in_use && (low <= key_hi);
  // last entry starting at or below the range low that still reaches it joins the merge
  assign back  = le_lo && !next_le_lo && (high >= key_lo);
  assign at_s  = !a && prev_a;
  assign tail  = !a && !prev_a;

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_EVAL: begin
        a <= le_lo && !back;
        b <= le_hi;
      end
      CELL_PLACE: begin
        if (at_s) begin
          low  <= key_lo;
          high <= key_hi;
        end else if (tail && ctl.make_room) begin
          low  <= prev_low;
          high <= prev_high;
        end
      end
      CELL_SHIFT: begin
        if (tail) begin
          low  <= next_low;
          high <= next_high;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/interval_set_insert.sv
// Top level: command sequencer and the chain of interval cells.
// Sorted table of disjoint inclusive intervals. An item is taken when start is high and busy is
// low; its result appears on result with done high for exactly one cycle and must be captured
// then. A read or a rejected empty range keeps busy through the evaluate state only; an insert
// keeps it through the evaluate and apply states and then a shift step for every stored entry
// that a merge swallows beyond the first, since the cell chain compacts the table one position
// per cycle. The result strobe follows the cycle in which the decision is made.
module interval_set_insert #(
  parameter int TABLE_DEPTH = isi_pkg::DEFAULT_TABLE_DEPTH,
  parameter int ID_BITS     = isi_pkg::DEFAULT_ID_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  isi_pkg::isi_item_t   item,
  output logic                 busy,
  output logic                 done,
  output isi_pkg::isi_result_t result
);
  import isi_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY,
    S_SHIFT
  } state_t;

  state_t          state;
  isi_item_t       item_q;
  logic [CW-1:0]   count;
  logic [CW-1:0]   gone_left;

  logic [ID_BITS-1:0] lo_k, hi_k, key_lo, key_hi;
  logic [ID_BITS-1:0] low  [TABLE_DEPTH];
  logic [ID_BITS-1:0] high [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] le_lo, a, b, at_s, in_use, rd_sel;
  logic [TABLE_DEPTH:0]   a_ext, b_ext;
  cell_ctl_t          ctl;

  logic [CW-1:0]      s_pos, e_pos, gone;
  logic               any_merge;
  logic [ID_BITS-1:0] first_low, last_high, ins_lo, ins_hi, rd_low, rd_high;
  logic               rd_ok;

  assign busy  = (state != S_IDLE);
  assign lo_k  = ID_BITS'(item_q.range_low);
  assign hi_k  = ID_BITS'(item_q.range_high);
  assign a_ext = {1'b0, a};
  assign b_ext = {1'b0, b};
  assign rd_ok = (32'(item_q.read_index) < 32'(count));

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      logic               nle, pa;
      logic [ID_BITS-1:0] pl, ph, nl, nh;
      assign in_use[gi] = (CW'(gi) < count);
      assign rd_sel[gi] = (32'(gi) == 32'(item_q.read_index));
      if (gi == 0) begin : g_first
        assign pa = 1'b1;
        assign pl = '0;
        assign ph = '0;
      end else begin : g_mid_l
        assign pa = a[gi-1];
        assign pl = low[gi-1];
        assign ph = high[gi-1];
      end
      if (gi == TABLE_DEPTH - 1) begin : g_last
        assign nle = 1'b0;
        assign nl  = '0;
        assign nh  = '0;
      end else begin : g_mid_r
        assign nle = le_lo[gi+1];
        assign nl  = low[gi+1];
        assign nh  = high[gi+1];
      end
      isi_cell #(
        .ID_BITS(ID_BITS)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .in_use    (in_use[gi]),
        .key_lo    (key_lo),
        .key_hi    (key_hi),
        .next_le_lo(nle),
        .prev_a    (pa),
        .prev_low  (pl),
        .prev_high (ph),
        .next_low  (nl),
        .next_high (nh),
        .le_lo     (le_lo[gi]),
        .a         (a[gi]),
        .b         (b[gi]),
        .at_s      (at_s[gi]),
        .low       (low[gi]),
        .high      (high[gi])
      );
    end
  endgenerate

  // flag boundaries give the merge span and the selected entries
  always_comb begin
    s_pos     = '0;
    e_pos     = '0;
    any_merge = 1'b0;
    first_low = '0;
    last_high = '0;
    rd_low    = '0;
    rd_high   = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (a_ext[i] && !a_ext[i+1]) s_pos = s_pos | CW'(i + 1);
      if (b_ext[i] && !b_ext[i+1]) e_pos = e_pos | CW'(i + 1);
      if (!a[i] && b[i]) any_merge = 1'b1;
      if (at_s[i]) first_low = first_low | low[i];
      if (b_ext[i] && !b_ext[i+1]) last_high = last_high | high[i];
      if (rd_sel[i]) begin
        rd_low  = rd_low | low[i];
        rd_high = rd_high | high[i];
      end
    end
  end

  assign gone   = e_pos - s_pos - CW'(1);
  assign ins_lo = (first_low < lo_k) ? first_low : lo_k;
  assign ins_hi = (last_high > hi_k) ? last_high : hi_k;

  always_comb begin
    ctl.op        = CELL_HOLD;
    ctl.make_room = 1'b0;
    key_lo        = lo_k;
    key_hi        = hi_k;
    case (state)
      S_EVAL: begin
        ctl.op = CELL_EVAL;
      end
      S_APPLY: begin
        if (any_merge) begin
          ctl.op = CELL_PLACE;
          key_lo = ins_lo;
          key_hi = ins_hi;
        end else if (count != CW'(TABLE_DEPTH)) begin
          ctl.op        = CELL_PLACE;
          ctl.make_room = 1'b1;
        end
      end
      S_SHIFT: begin
        ctl.op = CELL_SHIFT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      count     <= '0;
      gone_left <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            item_q <= item;
            state  <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (item_q.command == CMD_READ) begin
            done               <= 1'b1;
            result.entry_count <= 5'(count);
            if (rd_ok) begin
              result.status      <= STAT_READ_OK;
              result.entry_index <= 5'(item_q.read_index);
              result.entry_low   <= 32'(rd_low);
              result.entry_high  <= 32'(rd_high);
            end else begin
              result.status      <= STAT_READ_BEYOND;
              result.entry_index <= 5'(count);
              result.entry_low   <= '0;
              result.entry_high  <= '0;
            end
            state <= S_IDLE;
          end else if (lo_k > hi_k) begin
            done               <= 1'b1;
            result.status      <= STAT_EMPTY;
            result.entry_index <= 5'(count);
            result.entry_low   <= '0;
            result.entry_high  <= '0;
            result.entry_count <= 5'(count);
            state              <= S_IDLE;
          end else begin
            done  <= 1'b0;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          done <= 1'b1;
          if (any_merge) begin
            result.status      <= STAT_MERGED;
            result.entry_index <= 5'(s_pos);
            result.entry_low   <= 32'(ins_lo);
            result.entry_high  <= 32'(ins_hi);
            result.entry_count <= 5'(count - gone);
            count              <= count - gone;
            gone_left          <= gone;
            state              <= (gone != '0) ? S_SHIFT : S_IDLE;
          end else if (count == CW'(TABLE_DEPTH)) begin
            result.status      <= STAT_FULL;
            result.entry_index <= 5'(count);
            result.entry_low   <= '0;
            result.entry_high  <= '0;
            result.entry_count <= 5'(count);
            state              <= S_IDLE;
          end else begin
            result.status      <= STAT_NEW;
            result.entry_index <= 5'(s_pos);
            result.entry_low   <= 32'(lo_k);
            result.entry_high  <= 32'(hi_k);
            result.entry_count <= 5'(count + CW'(1));
            count              <= count + CW'(1);
            state              <= S_IDLE;
          end
        end
        S_SHIFT: begin
          done <= 1'b0;
          // close the gap left by swallowed entries, one position per cycle
          gone_left <= gone_left - CW'(1);
          if (gone_left == CW'(1)) state <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/interval_table_checker.sv
`timescale 1ns / 1ps
// Checker for the interval set: tracks the stored table and compares every result item.
module interval_table_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  isi_pkg::isi_item_t   item,
  input  logic                 done,
  input  isi_pkg::isi_result_t result,
  output int                   errors,
  output int                   pending
);
  import isi_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;

  logic [31:0] shadow_low [DEPTH];
  logic [31:0] shadow_high [DEPTH];
  int          shadow_count;
  isi_result_t awaited_results [$];
  isi_result_t want;
  int          reported = 0;

  // Apply one command to the shadow table and return the result item it causes.
  function automatic isi_result_t apply_command(input isi_item_t it);
    isi_result_t r;
    logic [31:0] lo;
    logic [31:0] hi;
    int          n;
    int          s;
    int          e;
    int          gone;
    r    = '0;
    lo   = it.range_low;
    hi   = it.range_high;
    n    = shadow_count;
    s    = 0;
    e    = 0;
    if (it.command == CMD_READ) begin
      if (int'(it.read_index) < n) begin
        r.status      = STAT_READ_OK;
        r.entry_index = 5'(it.read_index);
        r.entry_low   = shadow_low[it.read_index];
        r.entry_high  = shadow_high[it.read_index];
      end else begin
        r.status      = STAT_READ_BEYOND;
        r.entry_index = 5'(n);
      end
    end else if (lo > hi) begin
      r.status      = STAT_EMPTY;
      r.entry_index = 5'(n);
    end else begin
      for (int i = 0; i < n; i++) begin
        if (shadow_low[i] <= lo) s++;
        if (shadow_low[i] <= hi) e++;
      end
      // pull in the preceding entry when its high end reaches the range
      if (s > 0 && shadow_high[s-1] >= lo) s--;
      if (s == e) begin
        if (n >= DEPTH) begin
          r.status      = STAT_FULL;
          r.entry_index = 5'(n);
        end else begin
          for (int i = n; i > s; i--) begin
            shadow_low[i]  = shadow_low[i-1];
            shadow_high[i] = shadow_high[i-1];
          end
          shadow_low[s]  = lo;
          shadow_high[s] = hi;
          shadow_count   = n + 1;
          r.status       = STAT_NEW;
          r.entry_index  = 5'(s);
          r.entry_low    = lo;
          r.entry_high   = hi;
        end
      end else begin
        if (shadow_low[s] > lo) shadow_low[s] = lo;
        shadow_high[s] = (shadow_high[e-1] > hi) ? shadow_high[e-1] : hi;
        gone = e - s - 1;
        // compact the entries above the merged span
        for (int i = e; i < n; i++) begin
          shadow_low[i-gone]  = shadow_low[i];
          shadow_high[i-gone] = shadow_high[i];
        end
        shadow_count  = n - gone;
        r.status      = STAT_MERGED;
        r.entry_index = 5'(s);
        r.entry_low   = shadow_low[s];
        r.entry_high  = shadow_high[s];
      end
    end
    r.entry_count = 5'(shadow_count);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      shadow_count = 0;
      awaited_results.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      // retire the result first: an item accepted on this edge cannot have answered yet
      if (done) begin
        if (awaited_results.size() == 0) begin
          errors <= errors + 1;
          if (reported < 10) begin
            $display("%0t: unexpected result: status %0d index %0d low %h high %h count %0d",
                     $realtime, result.status, result.entry_index, result.entry_low,
                     result.entry_high, result.entry_count);
            reported++;
          end
        end else begin
          want = awaited_results.pop_front();
          if (result.status !== want.status || result.entry_index !== want.entry_index ||
              result.entry_low !== want.entry_low || result.entry_high !== want.entry_high ||
              result.entry_count !== want.entry_count) begin
            errors <= errors + 1;
            if (reported < 10) begin
              $display("%0t: mismatch: expected status %0d index %0d low %h high %h count %0d",
                       $realtime, want.status, want.entry_index, want.entry_low,
                       want.entry_high, want.entry_count);
              $display("%0t:           actual   status %0d index %0d low %h high %h count %0d",
                       $realtime, result.status, result.entry_index, result.entry_low,
                       result.entry_high, result.entry_count);
              reported++;
            end
          end
        end
      end
      // queue the expected result of an item accepted on this edge
      if (start && !busy) awaited_results = {awaited_results, apply_command(item)};
      pending <= awaited_results.size();
    end
  end

endmodule

### tb/tb_interval_set_insert.sv
`timescale 1ns / 1ps
// Testbench top: drives insert and read items into the interval set and gives the verdict.
module tb_interval_set_insert;
  import isi_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int REGION_ITEMS = 150;
  localparam int DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        done;
  isi_item_t   item;
  isi_result_t result;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  logic        burst_mode;
  logic [31:0] region_base;

  interval_set_insert dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  interval_table_checker table_check (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // End the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic isi_item_t make_insert(input logic [31:0] lo, input logic [31:0] hi);
    isi_item_t it;
    it.command    = CMD_INSERT;
    it.range_low  = lo;
    it.range_high = hi;
    it.read_index = 4'($urandom);
    return it;
  endfunction

  function automatic isi_item_t make_read(input logic [3:0] idx);
    isi_item_t it;
    it.command    = CMD_READ;
    it.range_low  = $urandom;
    it.range_high = $urandom;
    it.read_index = idx;
    return it;
  endfunction

  // Mostly short ranges packed into the current region, so they overlap, touch and fill the table.
  function automatic isi_item_t random_command();
    isi_item_t   it;
    int unsigned roll;
    logic [31:0] lo;
    roll = $urandom_range(99);
    lo   = region_base + $urandom_range(4095);
    if (roll < 20) begin
      it = make_read(4'($urandom));
    end else if (roll < 25) begin
      it = make_insert(lo + $urandom_range(64, 1), lo);
    end else if (roll < 26) begin
      it = make_insert($urandom, $urandom);
    end else if (roll < 32) begin
      it = make_insert(lo, lo + $urandom_range(1500, 256));
    end else begin
      it = make_insert(lo, lo + $urandom_range(40));
    end
    return it;
  endfunction

  task automatic send(input isi_item_t it);
    int unsigned gap;
    int unsigned roll;
    gap = 0;
    if (!burst_mode) begin
      roll = $urandom_range(99);
      if (roll < 22) gap = $urandom_range(3, 1);
      else if (roll < 30) gap = $urandom_range(40, 8);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item  <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    item        = '0;
    burst_mode  = 1'b0;
    region_base = $urandom_range(32'hFFFE_0000, 32'h0001_0000);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send(make_read(4'd0));
    send(make_insert(32'd5, 32'd3));
    send(make_insert(32'hFFFF_FFFF, 32'd0));
    send(make_insert(32'd0, 32'd0));
    send(make_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(make_insert(32'd1, 32'd1));
    send(make_insert(32'd10, 32'd20));
    send(make_insert(32'd15, 32'd30));
    send(make_insert(32'd5, 32'd12));
    send(make_read(4'd2));
    for (int k = 0; k < 12; k++) begin
      send(make_insert(32'd1000 + 32'(k * 16), 32'd1007 + 32'(k * 16)));
    end
    // table is full: a disjoint range is refused, an overlapping one still merges
    send(make_insert(32'd500, 32'd500));
    send(make_insert(32'd1000, 32'd1000));
    send(make_read(4'd15));
    send(make_insert(32'd0, 32'd5000));
    send(make_read(4'd1));
    send(make_read(4'd3));

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 64 == 0) burst_mode = ($urandom_range(3) == 0);
      if (k % REGION_ITEMS == REGION_ITEMS - 1) begin
        // sweep the old region into one entry before moving on
        send(make_insert(region_base, region_base + 32'd8191));
        region_base = $urandom_range(32'hFFFE_0000, 32'h0001_0000);
      end else begin
        send(random_command());
      end
    end
    start <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
